>>> design/char_lcd_decimal_writer_unit_defines.svh
// assertion macros for the lcd decimal writer
`ifndef CHAR_LCD_DECIMAL_WRITER_UNIT_DEFINES_SVH
`define CHAR_LCD_DECIMAL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLDW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cldw check failed");

// next-cycle implication, checked out of reset
`define CLDW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cldw check failed");

`endif

>>> design/cldw_pkg.sv
// shared constants and types for the lcd decimal writer
`timescale 1ns / 1ps

package cldw_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int VALUE_DIGITS = 10;
   localparam int MAX_DIGITS   = 10;
   localparam int ROW_WIDTH    = 2;
   localparam int COL_WIDTH    = 6;
   localparam int PAD_WIDTH    = 4;
   localparam int CNT_WIDTH    = $clog2(VALUE_WIDTH);

   localparam logic [7:0]           ADDR_CMD_BASE = 8'h80;
   localparam logic [7:0]           LINE2_OFFSET  = 8'h40;
   localparam logic [7:0]           ASCII_ZERO    = 8'h30;
   localparam logic [ROW_WIDTH-1:0] FIRST_ROW     = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_ADDR,
      EM_SKIP,
      EM_DIGIT
   } emit_state_type;

   typedef struct packed {
      logic [7:0]           addr;
      logic [PAD_WIDTH-1:0] pad;
   } emit_cmd_type;

endpackage

>>> design/cldw_dabble.sv
// bit-serial binary to bcd converter, one input bit per cycle
`timescale 1ns / 1ps

module cldw_dabble #(
   parameter int NUM_DIGITS = cldw_pkg::VALUE_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [cldw_pkg::VALUE_WIDTH-1:0] value,
   output logic                             done,
   output logic [NUM_DIGITS*4-1:0]          bcd
);

   localparam int BW = NUM_DIGITS * 4;

   logic                             running_ff, running_in;
   logic                             done_ff, done_in;
   logic [cldw_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [cldw_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic [BW-1:0]                    bcd_ff, bcd_in;
   logic [BW-1:0]                    adj;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      value_in   = value_ff;
      bcd_in     = bcd_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = cldw_pkg::CNT_WIDTH'(cldw_pkg::VALUE_WIDTH - 1);
         value_in   = value;
         bcd_in     = '0;
      end else if (running_ff) begin
         bcd_in   = {adj[BW-2:0], value_ff[cldw_pkg::VALUE_WIDTH-1]};
         value_in = {value_ff[cldw_pkg::VALUE_WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

>>> design/cldw_emit.sv
// byte sequencer: address command, then digits shifted out one nibble a cycle unless the receiver stalls
`timescale 1ns / 1ps

module cldw_emit #(
   parameter int MAX_DIGITS = cldw_pkg::MAX_DIGITS,
   parameter int NUM_DIGITS = cldw_pkg::VALUE_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  cldw_pkg::emit_cmd_type        cmd,
   input  logic [NUM_DIGITS*4-1:0]       bcd,
   output logic                          done,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_data,
   output logic [7:0]                    rsp_bus_byte,
   output logic                          rsp_last
);

   localparam int BW = NUM_DIGITS * 4;
   localparam int RW = $clog2(NUM_DIGITS + 1);

   cldw_pkg::emit_state_type state_ff, state_in;
   logic [BW-1:0] digits_ff, digits_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic [RW-1:0] target_ff, target_in;
   logic          natural_ff, natural_in;
   logic [7:0]    addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_data_ff, rsp_is_data_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          slot_free;
   logic [3:0]    top_digit;
   logic          skip;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_digit = digits_ff[BW-1 -: 4];
   // drop digits above the shown count, and leading zeros in natural mode
   assign skip = (remain_ff > target_ff) ||
                 (natural_ff && (top_digit == 4'd0) && (remain_ff > RW'(1)));

   always_comb begin
      state_in       = state_ff;
      digits_in      = digits_ff;
      remain_in      = remain_ff;
      target_in      = target_ff;
      natural_in     = natural_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      done           = 1'b0;
      unique case (state_ff)
         cldw_pkg::EM_IDLE: begin
            if (start) begin
               digits_in  = bcd;
               remain_in  = RW'(NUM_DIGITS);
               natural_in = (cmd.pad == '0);
               target_in  = ((cmd.pad == '0) || (RW'(cmd.pad) > RW'(MAX_DIGITS)))
                            ? RW'(MAX_DIGITS) : RW'(cmd.pad);
               addr_in    = cmd.addr;
               state_in   = cldw_pkg::EM_ADDR;
            end
         end
         cldw_pkg::EM_ADDR: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_is_data_in = 1'b0;
               rsp_byte_in    = addr_ff;
               rsp_last_in    = 1'b0;
               state_in       = cldw_pkg::EM_SKIP;
            end
         end
         cldw_pkg::EM_SKIP: begin
            if (skip) begin
               digits_in = {digits_ff[BW-5:0], 4'd0};
               remain_in = remain_ff - 1'b1;
               // a dropped nonzero digit means the remaining zeros are shown
               if (top_digit != 4'd0) begin
                  natural_in = 1'b0;
               end
            end else begin
               state_in = cldw_pkg::EM_DIGIT;
            end
         end
         cldw_pkg::EM_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_is_data_in = 1'b1;
               rsp_byte_in    = cldw_pkg::ASCII_ZERO | {4'd0, top_digit};
               rsp_last_in    = (remain_ff == RW'(1));
               digits_in      = {digits_ff[BW-5:0], 4'd0};
               remain_in      = remain_ff - 1'b1;
               if (remain_ff == RW'(1)) begin
                  state_in = cldw_pkg::EM_IDLE;
                  done     = 1'b1;
               end
            end
         end
         default: begin
            state_in = cldw_pkg::EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cldw_pkg::EM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff      <= digits_in;
      remain_ff      <= remain_in;
      target_ff      <= target_in;
      natural_ff     <= natural_in;
      addr_ff        <= addr_in;
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_data  = rsp_is_data_ff;
   assign rsp_bus_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> design/char_lcd_decimal_writer_unit.sv
// lcd decimal writer: set-address command then ascii digits of a 32-bit value
// order: the bit-serial bcd conversion runs first, then the address beat is sent; the first
// digit follows once the skipped positions are dropped, then one per cycle unless stalled
// requests: a new one is taken only once the last has run through the bit-serial bcd
// conversion and the nibble-wide output shifter; req_stall is high until then
// reset: synchronous, active high; returns to idle with no beat pending
`timescale 1ns / 1ps

`include "char_lcd_decimal_writer_unit_defines.svh"

module char_lcd_decimal_writer_unit #(
   parameter int MAX_DIGITS = cldw_pkg::MAX_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cldw_pkg::ROW_WIDTH-1:0]   req_row_select,
   input  logic [cldw_pkg::COL_WIDTH-1:0]   req_column,
   input  logic [cldw_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [cldw_pkg::PAD_WIDTH-1:0]   req_pad_width,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_data,
   output logic [7:0]                       rsp_bus_byte,
   output logic                             rsp_last
);

   // enough digits for any 32-bit value so the natural count is always known
   localparam int NUM_DIGITS = (MAX_DIGITS > cldw_pkg::VALUE_DIGITS)
                               ? MAX_DIGITS : cldw_pkg::VALUE_DIGITS;

   cldw_pkg::ctl_state_type state_ff, state_in;
   cldw_pkg::emit_cmd_type  cmd_ff, cmd_in;
   logic                    accept;
   logic                    conv_done;
   logic                    emit_done;
   logic [NUM_DIGITS*4-1:0] bcd;

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      req_stall = (state_ff != cldw_pkg::ST_IDLE);
      unique case (state_ff)
         cldw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in.addr = cldw_pkg::ADDR_CMD_BASE + {2'd0, req_column} - 8'd1 +
                             ((req_row_select != cldw_pkg::FIRST_ROW)
                              ? cldw_pkg::LINE2_OFFSET : 8'd0);
               cmd_in.pad  = req_pad_width;
               state_in    = cldw_pkg::ST_CONV;
            end
         end
         cldw_pkg::ST_CONV: begin
            if (conv_done) begin
               state_in = cldw_pkg::ST_EMIT;
            end
         end
         cldw_pkg::ST_EMIT: begin
            if (emit_done) begin
               state_in = cldw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cldw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cldw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
   end

   cldw_dabble #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_value),
      .done  (conv_done),
      .bcd   (bcd)
   );

   cldw_emit #(
      .MAX_DIGITS (MAX_DIGITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .start        (conv_done),
      .cmd          (cmd_ff),
      .bcd          (bcd),
      .done         (emit_done),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_data  (rsp_is_data),
      .rsp_bus_byte (rsp_bus_byte),
      .rsp_last     (rsp_last)
   );

   `CLDW_ASSERT_NEXT(a_accept_starts_conv, accept, state_ff == cldw_pkg::ST_CONV)
   `CLDW_ASSERT_NOW(a_conv_done_in_conv, conv_done, state_ff == cldw_pkg::ST_CONV)
   `CLDW_ASSERT_NOW(a_emit_done_in_emit, emit_done, state_ff == cldw_pkg::ST_EMIT)
   `CLDW_ASSERT_NOW(a_last_is_digit, rsp_valid && rsp_last, rsp_is_data)

endmodule

>>> dv/char_lcd_decimal_writer_unit_test.sv
// self-checking bench for the lcd decimal writer: address command and ascii digit beats
`timescale 1ns / 1ps

module char_lcd_decimal_writer_unit_test;

   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 60;
   localparam int RANDOM_REQS = 190;

   typedef struct packed {
      logic [cldw_pkg::ROW_WIDTH-1:0]   row_select;
      logic [cldw_pkg::COL_WIDTH-1:0]   column;
      logic [cldw_pkg::VALUE_WIDTH-1:0] value;
      logic [cldw_pkg::PAD_WIDTH-1:0]   pad_width;
   } lcd_req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_beat_type;

   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_stall;
   logic [cldw_pkg::ROW_WIDTH-1:0]   req_row_select = '0;
   logic [cldw_pkg::COL_WIDTH-1:0]   req_column     = '0;
   logic [cldw_pkg::VALUE_WIDTH-1:0] req_value      = '0;
   logic [cldw_pkg::PAD_WIDTH-1:0]   req_pad_width  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall      = 1'b0;
   logic                             rsp_is_data;
   logic [7:0]                       rsp_bus_byte;
   logic                             rsp_last;

   lcd_req_type  pending_reqs[$];
   lcd_beat_type expected_beats[$];
   lcd_req_type  cur_req = '0;

   int req_accepted  = 0;
   int beats_checked = 0;
   int errors        = 0;
   int idle_cycles   = 0;

   char_lcd_decimal_writer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_select (req_row_select),
      .req_column     (req_column),
      .req_value      (req_value),
      .req_pad_width  (req_pad_width),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_data    (rsp_is_data),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // address command first, then the shown digits most significant first
   function automatic void predict_lcd_beats(input lcd_req_type r);
      int unsigned     shown;
      int unsigned     k;
      longint unsigned scale;
      logic [7:0]      addr;
      logic [3:0]      digit;
      if (r.pad_width == '0) begin
         shown = 1;
         scale = 10;
         while (scale <= r.value) begin
            shown++;
            scale *= 10;
         end
      end else begin
         shown = 32'(r.pad_width);
      end
      if (shown > cldw_pkg::MAX_DIGITS)
         shown = cldw_pkg::MAX_DIGITS;
      addr = cldw_pkg::ADDR_CMD_BASE + {2'b00, r.column} - 8'd1;
      if (r.row_select != cldw_pkg::FIRST_ROW)
         addr = addr + cldw_pkg::LINE2_OFFSET;
      expected_beats.push_back('{is_data: 1'b0, bus_byte: addr, last: 1'b0});
      for (k = shown; k >= 1; k--) begin
         scale = 1;
         repeat (k - 1) scale *= 10;
         digit = 4'((longint'(r.value) / scale) % 10);
         expected_beats.push_back('{is_data: 1'b1, bus_byte: cldw_pkg::ASCII_ZERO + digit,
                                    last: (k == 1)});
      end
   endfunction

   task automatic queue_request(input logic [cldw_pkg::ROW_WIDTH-1:0] row,
                                input logic [cldw_pkg::COL_WIDTH-1:0] col,
                                input logic [cldw_pkg::VALUE_WIDTH-1:0] val,
                                input logic [cldw_pkg::PAD_WIDTH-1:0] pad);
      pending_reqs.push_back('{row_select: row, column: col, value: val, pad_width: pad});
   endtask

   // sender: bursts of requests separated by random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(8, 1);
         gap_left   = $urandom_range(3);
      end else begin
         if (req_valid && !req_stall) begin
            predict_lcd_beats(cur_req);
            req_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_valid      <= 1'b1;
               req_row_select <= cur_req.row_select;
               req_column     <= cur_req.column;
               req_value      <= cur_req.value;
               req_pad_width  <= cur_req.pad_width;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(12, 1);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off once traffic is flowing
   int  stall_mode = 0;
   int  mode_left  = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && req_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(3);
            mode_left  = $urandom_range(80, 20);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(3) == 0);
               2: rsp_stall <= ($urandom_range(3) != 0);
               default: rsp_stall <= !rsp_stall;
            endcase
         end
      end
   end

   // result checker
   lcd_beat_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat is_data=%0b byte=%02h last=%0b", $time,
                     rsp_is_data, rsp_bus_byte, rsp_last);
            errors++;
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_is_data !== want.is_data) begin
               $display("%0t: is_data expected %0b actual %0b", $time,
                        want.is_data, rsp_is_data);
               errors++;
            end
            if (rsp_bus_byte !== want.bus_byte) begin
               $display("%0t: bus_byte expected %02h actual %02h", $time,
                        want.bus_byte, rsp_bus_byte);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles, %0d beats outstanding", $time,
                  idle_cycles, expected_beats.size());
         $display("FAIL char_lcd_decimal_writer_unit");
         $finish;
      end
   end

   initial begin
      longint unsigned                  p;
      logic [cldw_pkg::VALUE_WIDTH-1:0] v;
      logic [cldw_pkg::PAD_WIDTH-1:0]   pad;
      logic [cldw_pkg::COL_WIDTH-1:0]   col;

      // corner requests: value and column extremes, wraparound, padding and truncation
      queue_request(2'd1, 6'd1,  32'd0,          4'd0);
      queue_request(2'd2, 6'd40, 32'hFFFF_FFFF,  4'd0);
      queue_request(2'd1, 6'd1,  32'hFFFF_FFFF,  4'd10);
      queue_request(2'd0, 6'd0,  32'd1,          4'd10);
      queue_request(2'd1, 6'd0,  32'd7,          4'd0);
      queue_request(2'd3, 6'd63, 32'd12345,      4'd0);
      queue_request(2'd1, 6'd63, 32'd9,          4'd0);
      queue_request(2'd2, 6'd1,  32'd10,         4'd0);
      queue_request(2'd1, 6'd20, 32'd1234567,    4'd3);
      queue_request(2'd2, 6'd5,  32'd42,         4'd8);
      queue_request(2'd1, 6'd7,  32'd0,          4'd5);
      queue_request(2'd2, 6'd8,  32'd987654321,  4'd15);
      queue_request(2'd1, 6'd9,  32'd1000000000, 4'd11);
      queue_request(2'd2, 6'd10, 32'd999999999,  4'd0);
      queue_request(2'd1, 6'd40, 32'hFFFF_FFFF,  4'd1);
      queue_request(2'd0, 6'd33, 32'd123,        4'd2);
      queue_request(2'd3, 6'd1,  32'h8000_0000,  4'd0);
      queue_request(2'd1, 6'd2,  32'd99,         4'd9);
      queue_request(2'd2, 6'd3,  32'd100,        4'd0);
      queue_request(2'd1, 6'd21, 32'd65535,      4'd4);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: begin
               // around a power of ten, where the digit count changes
               p = 1;
               repeat ($urandom_range(9)) p *= 10;
               p = p + $urandom_range(2);
               v = 32'(p - 1);
            end
            3: v = 32'hFFFF_FFFF - $urandom_range(300);
            4: v = $urandom >> $urandom_range(31);
            default: v = $urandom_range(99999);
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3: pad = '0;
            4:          pad = 4'($urandom_range(15, 11));
            default:    pad = 4'($urandom_range(10, 1));
         endcase
         col = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(40, 1));
         queue_request(2'($urandom_range(3)), col, v, pad);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d requests (rows 0-3, columns 0-63, pad 0-15), %0d beats checked",
               req_accepted, beats_checked);
      $display("long receiver hold-off applied: %0d, mismatches: %0d", hold_done, errors);
      if (errors == 0)
         $display("PASS char_lcd_decimal_writer_unit");
      else
         $display("FAIL char_lcd_decimal_writer_unit");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/cldw_pkg.sv
design/cldw_dabble.sv
design/cldw_emit.sv
design/char_lcd_decimal_writer_unit.sv
dv/char_lcd_decimal_writer_unit_test.sv
